// ===== hdl/msm_pkg.sv =====
`timescale 1ns / 1ps

package msm_pkg;

   // Default table sizes
   localparam int NODE_COUNT_DEF    = 1024;
   localparam int ALPHABET_SIZE_DEF = 26;

   // Field widths
   localparam int MODE_W  = 2;
   localparam int SYMW    = 5;
   localparam int NUSED_W = 11;

   // Item modes
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BUILD = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [SYMW-1:0]   symbol;
      logic              last;
   } req_type;

   typedef struct packed {
      logic               found;
      logic               overflow;
      logic [NUSED_W-1:0] nodes_used;
   } rsp_type;

endpackage

// ===== hdl/multi_pattern_string_matcher.sv =====
`timescale 1ns / 1ps
// Aho-Corasick matcher. One transaction at a time, 1 result per transaction.
// Add reads the edge table unless its letter lies outside the alphabet; scan walks
// failure links until an edge exists (none outside the alphabet); build queues the root's
// children, then visits the nodes breadth first and walks failure links per edge below depth one.
// Clear wipes the edge table at one edge-table entry per cycle.
// Reset runs the same sweep before req_ready rises; the node counter, the found flag
// and the walks return to the root.
module multi_pattern_string_matcher
   import msm_pkg::*;
#(
   parameter int NODE_COUNT    = NODE_COUNT_DEF,
   parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int NW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int SW    = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int DEPTH = NODE_COUNT * ALPHABET_SIZE;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_ADD_RD, S_ADD_CHK, S_ADV_RD, S_ADV_CHK, S_ADV_FAIL,
      S_TERM_RD, S_TERM_CHK, S_B_ROOT_RD, S_B_ROOT_CHK, S_B_POP, S_B_XQ,
      S_B_XF, S_B_CRD, S_B_CCHK, S_RESP
   } state_type;

   // Memories
   logic [NW-1:0] child_mem [DEPTH];
   logic [NW-1:0] fail_mem  [NODE_COUNT];
   logic          term_mem  [NODE_COUNT];
   logic [NW-1:0] queue_mem [NODE_COUNT];

   state_type     state_ff;
   req_type       req_ff;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;
   logic [NW-1:0] node_counter_ff, insert_ff, scan_ff;
   logic          found_ff;
   logic [AW-1:0] clr_cnt_ff;
   logic          clr_item_ff;
   logic          res_found_ff, res_ovf_ff;
   logic [NW-1:0] adv_node_ff, adv_res_ff;
   logic [SW-1:0] adv_sym_ff, s_ff;
   logic [NW-1:0] head_ff, tail_ff, x_ff, fx_ff, c_ff;

   logic [NW-1:0] child_rdata, fail_rdata, q_rdata;
   logic          term_rdata;

   logic          child_we, fail_we, term_we, q_we;
   logic [AW-1:0] child_waddr, child_raddr;
   logic [NW-1:0] child_wdata, fail_waddr, fail_wdata, fail_raddr;
   logic [NW-1:0] term_waddr, term_raddr, q_wdata;
   logic          term_wdata;
   logic [NW-1:0] node_sel;
   logic [SW-1:0] sym_sel;

   logic [NW-1:0] new_node;
   logic          room;
   logic          req_sym_ok;

   assign new_node   = node_counter_ff + NW'(1);
   assign room       = ({1'b0, node_counter_ff} + (NW+1)'(1)) < (NW+1)'(NODE_COUNT);
   assign req_sym_ok = int'(req_data.symbol) < ALPHABET_SIZE;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Edge table address: row base plus letter
   always_comb begin
      unique case (state_ff)
         S_ADD_RD, S_ADD_CHK: begin
            node_sel = insert_ff;
            sym_sel  = SW'(req_ff.symbol);
         end
         S_B_ROOT_RD: begin
            node_sel = '0;
            sym_sel  = s_ff;
         end
         S_B_CRD: begin
            node_sel = x_ff;
            sym_sel  = s_ff;
         end
         default: begin
            node_sel = adv_node_ff;
            sym_sel  = adv_sym_ff;
         end
      endcase
      child_raddr = AW'(node_sel) * AW'(ALPHABET_SIZE) + AW'(sym_sel);
      fail_raddr  = (state_ff == S_B_XQ) ? q_rdata : adv_node_ff;
      term_raddr  = adv_res_ff;
   end

   // Memory write ports
   always_comb begin
      child_we    = 1'b0;
      child_waddr = child_raddr;
      child_wdata = new_node;
      fail_we     = 1'b0;
      fail_waddr  = new_node;
      fail_wdata  = '0;
      term_we     = 1'b0;
      term_waddr  = new_node;
      term_wdata  = 1'b1;
      q_we        = 1'b0;
      q_wdata     = c_ff;
      unique case (state_ff)
         S_CLR: begin
            child_we    = 1'b1;
            child_waddr = clr_cnt_ff;
            child_wdata = '0;
            term_we     = int'(clr_cnt_ff) < NODE_COUNT;
            term_waddr  = NW'(clr_cnt_ff);
            term_wdata  = 1'b0;
         end
         S_ADD_CHK: begin
            if (child_rdata != '0) begin
               term_we    = req_ff.last;
               term_waddr = child_rdata;
            end else if (room) begin
               child_we = 1'b1;
               fail_we  = 1'b1;
               term_we  = req_ff.last;
            end
         end
         S_B_ROOT_CHK: begin
            if (child_rdata != '0) begin
               fail_we    = 1'b1;
               fail_waddr = child_rdata;
               q_we       = 1'b1;
               q_wdata    = child_rdata;
            end
         end
         S_TERM_CHK: begin
            if (req_ff.mode != MODE_SCAN) begin
               fail_we    = 1'b1;
               fail_waddr = c_ff;
               fail_wdata = adv_res_ff;
               term_we    = term_rdata;
               term_waddr = c_ff;
               q_we       = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (child_we) begin
         child_mem[child_waddr] <= child_wdata;
      end
      child_rdata <= child_mem[child_raddr];
   end

   always_ff @(posedge clock) begin
      if (fail_we) begin
         fail_mem[fail_waddr] <= fail_wdata;
      end
      fail_rdata <= fail_mem[fail_raddr];
   end

   always_ff @(posedge clock) begin
      if (term_we) begin
         term_mem[term_waddr] <= term_wdata;
      end
      term_rdata <= term_mem[term_raddr];
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[tail_ff] <= q_wdata;
      end
      q_rdata <= queue_mem[head_ff];
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLR;
         rsp_valid_ff    <= 1'b0;
         clr_cnt_ff      <= '0;
         clr_item_ff     <= 1'b0;
         node_counter_ff <= '0;
         insert_ff       <= '0;
         scan_ff         <= '0;
         found_ff        <= 1'b0;
         head_ff         <= '0;
         tail_ff         <= '0;
      end else begin
         // Result leaves; S_RESP handles its own hand-off
         if (rsp_ready && state_ff != S_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLR: begin
               clr_cnt_ff <= clr_cnt_ff + AW'(1);
               if (int'(clr_cnt_ff) == DEPTH - 1) begin
                  state_ff <= clr_item_ff ? S_RESP : S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  req_ff       <= req_data;
                  res_found_ff <= 1'b0;
                  res_ovf_ff   <= 1'b0;
                  unique case (req_data.mode)
                     MODE_CLEAR: begin
                        node_counter_ff <= '0;
                        insert_ff       <= '0;
                        scan_ff         <= '0;
                        found_ff        <= 1'b0;
                        clr_cnt_ff      <= '0;
                        clr_item_ff     <= 1'b1;
                        state_ff        <= S_CLR;
                     end
                     MODE_ADD: begin
                        if (req_sym_ok) begin
                           state_ff <= S_ADD_RD;
                        end else begin
                           if (req_data.last) begin
                              insert_ff <= '0;
                           end
                           state_ff <= S_RESP;
                        end
                     end
                     MODE_BUILD: begin
                        s_ff     <= '0;
                        head_ff  <= '0;
                        tail_ff  <= '0;
                        state_ff <= S_B_ROOT_RD;
                     end
                     default: begin
                        adv_node_ff <= scan_ff;
                        adv_sym_ff  <= SW'(req_data.symbol);
                        adv_res_ff  <= '0;
                        state_ff    <= req_sym_ok ? S_ADV_RD : S_TERM_RD;
                     end
                  endcase
               end
            end
            S_ADD_RD: begin
               state_ff <= S_ADD_CHK;
            end
            S_ADD_CHK: begin
               if (child_rdata != '0) begin
                  insert_ff <= req_ff.last ? '0 : child_rdata;
               end else if (room) begin
                  node_counter_ff <= new_node;
                  insert_ff       <= req_ff.last ? '0 : new_node;
               end else begin
                  res_ovf_ff <= 1'b1;
                  if (req_ff.last) begin
                     insert_ff <= '0;
                  end
               end
               state_ff <= S_RESP;
            end
            // Failure-link walk, shared by scan and build
            S_ADV_RD: begin
               state_ff <= S_ADV_CHK;
            end
            S_ADV_CHK: begin
               if (child_rdata != '0 || adv_node_ff == '0) begin
                  adv_res_ff <= child_rdata;
                  state_ff   <= S_TERM_RD;
               end else begin
                  state_ff <= S_ADV_FAIL;
               end
            end
            S_ADV_FAIL: begin
               adv_node_ff <= fail_rdata;
               state_ff    <= S_ADV_RD;
            end
            S_TERM_RD: begin
               state_ff <= S_TERM_CHK;
            end
            S_TERM_CHK: begin
               if (req_ff.mode == MODE_SCAN) begin
                  res_found_ff <= found_ff | term_rdata;
                  if (req_ff.last) begin
                     scan_ff  <= '0;
                     found_ff <= 1'b0;
                  end else begin
                     scan_ff  <= adv_res_ff;
                     found_ff <= found_ff | term_rdata;
                  end
                  state_ff <= S_RESP;
               end else begin
                  tail_ff <= tail_ff + NW'(1);
                  if (int'(s_ff) == ALPHABET_SIZE - 1) begin
                     state_ff <= S_B_POP;
                  end else begin
                     s_ff     <= s_ff + SW'(1);
                     state_ff <= S_B_CRD;
                  end
               end
            end
            // Build: queue the root's children
            S_B_ROOT_RD: begin
               state_ff <= S_B_ROOT_CHK;
            end
            S_B_ROOT_CHK: begin
               if (child_rdata != '0) begin
                  tail_ff <= tail_ff + NW'(1);
               end
               if (int'(s_ff) == ALPHABET_SIZE - 1) begin
                  state_ff <= S_B_POP;
               end else begin
                  s_ff     <= s_ff + SW'(1);
                  state_ff <= S_B_ROOT_RD;
               end
            end
            // Build: breadth-first over the queue
            S_B_POP: begin
               if (head_ff == tail_ff) begin
                  state_ff <= S_RESP;
               end else begin
                  head_ff  <= head_ff + NW'(1);
                  state_ff <= S_B_XQ;
               end
            end
            S_B_XQ: begin
               x_ff     <= q_rdata;
               state_ff <= S_B_XF;
            end
            S_B_XF: begin
               fx_ff    <= fail_rdata;
               s_ff     <= '0;
               state_ff <= S_B_CRD;
            end
            S_B_CRD: begin
               state_ff <= S_B_CCHK;
            end
            S_B_CCHK: begin
               if (child_rdata != '0) begin
                  c_ff        <= child_rdata;
                  adv_node_ff <= fx_ff;
                  adv_sym_ff  <= s_ff;
                  state_ff    <= S_ADV_RD;
               end else if (int'(s_ff) == ALPHABET_SIZE - 1) begin
                  state_ff <= S_B_POP;
               end else begin
                  s_ff     <= s_ff + SW'(1);
                  state_ff <= S_B_CRD;
               end
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.found       <= res_found_ff;
                  rsp_ff.overflow    <= res_ovf_ff;
                  rsp_ff.nodes_used  <= NUSED_W'(node_counter_ff);
                  state_ff           <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Checks
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.overflow |-> rsp_ff.nodes_used == NUSED_W'(NODE_COUNT - 1))
      else $error("overflow reported with free nodes");

   a_scan_alloc: assert property (@(posedge clock) disable iff (reset)
      scan_ff <= node_counter_ff)
      else $error("scan walk on unallocated node");

   a_insert_alloc: assert property (@(posedge clock) disable iff (reset)
      insert_ff <= node_counter_ff)
      else $error("insert walk on unallocated node");

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_B_POP |-> head_ff <= tail_ff)
      else $error("build queue head passed tail");

endmodule

// ===== tb/sv/multi_pattern_string_matcher_test.sv =====
`timescale 1ns / 1ps

module multi_pattern_string_matcher_test;
   import msm_pkg::*;

   localparam int NODES = NODE_COUNT_DEF;
   localparam int ALPHA = ALPHABET_SIZE_DEF;
   localparam int CYCLE_LIMIT = 3000000;
   // Directed and mixed phases; the table fill at the end adds about a thousand more
   localparam int ITEM_TARGET = 120;
   localparam int LONG_HOLD = 400;

   // Expected-result tracker with its own copy of the automaton
   class match_scoreboard;
      logic [9:0] child[NODES*ALPHA];
      logic [9:0] fail_link[NODES];
      bit         term[NODES];
      int         node_cnt;
      int         ins_node;
      int         scan_node;
      bit         found_flag;
      int         bfs[NODES];
      rsp_type    expected_q[$];
      int         errors;
      int         n_scan;
      int         n_found;
      int         n_ovf;
      int         n_checked;

      function new();
         errors = 0;
         n_scan = 0;
         n_found = 0;
         n_ovf = 0;
         n_checked = 0;
         wipe();
      endfunction

      function void wipe();
         foreach (child[i]) child[i] = '0;
         foreach (fail_link[i]) fail_link[i] = '0;
         foreach (term[i]) term[i] = 1'b0;
         node_cnt = 0;
         ins_node = 0;
         scan_node = 0;
         found_flag = 1'b0;
      endfunction

      function int edge_of(int nd, int s);
         return int'(child[nd*ALPHA + s]);
      endfunction

      // Walk failure links until an edge on s exists, then take it
      function int step_walk(int nd, int s);
         int guard;
         guard = 0;
         while (nd != 0 && edge_of(nd, s) == 0 && guard < NODES) begin
            nd = int'(fail_link[nd]);
            guard++;
         end
         if (guard >= NODES) nd = 0;
         return edge_of(nd, s);
      endfunction

      // Breadth-first failure link pass
      function void link_pass();
         int head, tail, x, c, f;
         head = 0;
         tail = 0;
         for (int s = 0; s < ALPHA; s++) begin
            c = edge_of(0, s);
            if (c != 0 && tail < NODES) begin
               fail_link[c] = '0;
               bfs[tail++] = c;
            end
         end
         while (head < tail) begin
            x = bfs[head++];
            for (int s = 0; s < ALPHA; s++) begin
               c = edge_of(x, s);
               if (c != 0) begin
                  f = step_walk(int'(fail_link[x]), s);
                  fail_link[c] = f[9:0];
                  if (term[f]) term[c] = 1'b1;
                  if (tail < NODES) bfs[tail++] = c;
               end
            end
         end
      endfunction

      // Predict the result of one accepted transaction
      function void note(req_type r);
         rsp_type e;
         int      s, slot;
         bit      stored;
         e = '0;
         s = int'(r.symbol);
         case (r.mode)
            MODE_CLEAR: wipe();
            MODE_ADD: begin
               stored = 1'b0;
               if (s < ALPHA) begin
                  slot = ins_node*ALPHA + s;
                  if (child[slot] != 0) begin
                     ins_node = int'(child[slot]);
                     stored = 1'b1;
                  end else if (node_cnt + 1 < NODES) begin
                     node_cnt++;
                     child[slot] = node_cnt[9:0];
                     fail_link[node_cnt] = '0;
                     ins_node = node_cnt;
                     stored = 1'b1;
                  end else begin
                     e.overflow = 1'b1;
                     n_ovf++;
                  end
               end
               if (r.last) begin
                  if (stored) term[ins_node] = 1'b1;
                  ins_node = 0;
               end
            end
            MODE_BUILD: link_pass();
            default: begin
               n_scan++;
               if (s < ALPHA) scan_node = step_walk(scan_node, s);
               else scan_node = 0;
               if (term[scan_node]) found_flag = 1'b1;
               e.found = found_flag;
               if (found_flag) n_found++;
               if (r.last) begin
                  scan_node = 0;
                  found_flag = 1'b0;
               end
            end
         endcase
         e.nodes_used = node_cnt[NUSED_W-1:0];
         expected_q.push_back(e);
      endfunction

      function void check(rsp_type a);
         rsp_type e;
         n_checked++;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %p", $time, a);
            return;
         end
         e = expected_q.pop_front();
         if (a.found !== e.found) begin
            errors++;
            $display("%0t: found expected %0b actual %0b", $time, e.found, a.found);
         end
         if (a.overflow !== e.overflow) begin
            errors++;
            $display("%0t: overflow expected %0b actual %0b", $time, e.overflow,
                     a.overflow);
         end
         if (a.nodes_used !== e.nodes_used) begin
            errors++;
            $display("%0t: nodes_used expected %0d actual %0d", $time, e.nodes_used,
                     a.nodes_used);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   match_scoreboard sb;
   int cycles = 0;
   int items_sent;
   int burst_left;
   int hold_asked;
   int clears_done;

   multi_pattern_string_matcher i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      items_sent = 0;
      burst_left = 0;
      hold_asked = 0;
      clears_done = 0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("multi_pattern_string_matcher regression: fail");
         $finish;
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check(rsp_data);
   end

   // Receiver: stall pattern that changes style, plus long holds on request
   initial begin : receiver
      int style, left, hold_seen;
      style = 0;
      left = 0;
      hold_seen = 0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            rsp_ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         if (left == 0) begin
            style = $urandom_range(0, 2);
            left = $urandom_range(20, 300);
         end
         left--;
         case (style)
            0: rsp_ready = 1'b1;
            1: rsp_ready = ($urandom_range(0, 3) != 0);
            default: rsp_ready = ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // One transaction: hold valid until accepted; bursts end in random gaps
   task automatic send(logic [MODE_W-1:0] m, int s, bit l);
      req_type r;
      r.mode = m;
      r.symbol = s[SYMW-1:0];
      r.last = l;
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(0, 1) ? $urandom_range(1, 12) : 0) @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid = 1'b1;
      req_data = r;
      do @(posedge clock); while (!req_ready);
      sb.note(r);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
   endtask

   task automatic add_word(int len, int top);
      for (int i = 0; i < len; i++)
         send(MODE_ADD, ($urandom_range(0, 19) == 0) ? $urandom_range(26, 31)
                                                     : $urandom_range(0, top),
              i == len - 1);
   endtask

   task automatic scan_text(int len, int top);
      for (int i = 0; i < len; i++)
         send(MODE_SCAN, ($urandom_range(0, 29) == 0) ? $urandom_range(26, 31)
                                                      : $urandom_range(0, top),
              i == len - 1);
   endtask

   task automatic do_clear();
      send(MODE_CLEAR, $urandom_range(0, 31), $urandom_range(0, 1) == 1);
      clears_done++;
   endtask

   initial begin : stimulus
      int top, n;
      int he[2], she[3], his[3], hers[4], ushers[6];
      he = '{7, 4};
      she = '{18, 7, 4};
      his = '{7, 8, 18};
      hers = '{7, 4, 17, 18};
      ushers = '{20, 18, 7, 4, 17, 18};
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Directed: empty table, classic pattern set, out-of-range symbols
      send(MODE_SCAN, 0, 1'b0);
      send(MODE_ADD, 31, 1'b1);
      foreach (he[i]) send(MODE_ADD, he[i], i == 1);
      foreach (she[i]) send(MODE_ADD, she[i], i == 2);
      foreach (his[i]) send(MODE_ADD, his[i], i == 2);
      foreach (hers[i]) send(MODE_ADD, hers[i], i == 3);
      send(MODE_BUILD, 0, 1'b0);
      foreach (ushers[i]) send(MODE_SCAN, ushers[i], i == 5);
      send(MODE_SCAN, 7, 1'b0);
      send(MODE_SCAN, 4, 1'b0);
      send(MODE_SCAN, 31, 1'b0);
      send(MODE_SCAN, 25, 1'b1);
      send(MODE_ADD, 25, 1'b1);
      send(MODE_SCAN, 25, 1'b1);
      send(MODE_BUILD, 31, 1'b1);
      send(MODE_SCAN, 25, 1'b1);
      drain();
      do_clear();

      // Random phases of pattern sets and texts
      while (items_sent < ITEM_TARGET) begin
         if (clears_done < 6 && $urandom_range(0, 5) == 0) do_clear();
         top = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(5, 25);
         n = $urandom_range(1, 6);
         repeat (n) add_word($urandom_range(1, 5), top);
         if ($urandom_range(0, 9) != 0) send(MODE_BUILD, $urandom_range(0, 31),
                                             $urandom_range(0, 1) == 1);
         if ($urandom_range(0, 7) == 0) hold_asked++;
         repeat ($urandom_range(1, 5)) scan_text($urandom_range(1, 20), top);
         if ($urandom_range(0, 3) == 0) begin
            add_word($urandom_range(1, 4), top);
            scan_text($urandom_range(3, 12), top);
            send(MODE_BUILD, 0, 1'b0);
            scan_text($urandom_range(3, 12), top);
         end
         if ($urandom_range(0, 4) == 0) drain();
      end
      hold_asked++;
      scan_text(20, 25);
      drain();

      // Fill the node table to the brim, then push past it
      do_clear();
      while (sb.node_cnt < NODES - 1)
         send(MODE_ADD, $urandom_range(0, 25), $urandom_range(0, 39) == 0);
      repeat (6) send(MODE_ADD, $urandom_range(0, 25), $urandom_range(0, 1) == 1);
      send(MODE_ADD, $urandom_range(0, 25), 1'b1);
      send(MODE_BUILD, 0, 1'b0);
      scan_text(30, 25);
      send(MODE_ADD, 31, 1'b1);
      send(MODE_SCAN, 31, 1'b1);
      drain();
      repeat (200) @(negedge clock);

      $display("covered %0d transactions: %0d scans (%0d found), %0d overflows",
               items_sent, sb.n_scan, sb.n_found, sb.n_ovf);
      $display("%0d clears, %0d results checked", clears_done, sb.n_checked);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("multi_pattern_string_matcher regression: pass");
      end else begin
         $display("multi_pattern_string_matcher regression: fail");
      end
      $finish;
   end

endmodule
